@@ rtl/hsw_pkg.sv @@
// ----------------------------------------------------------------------------
// hsw_pkg
// Types, constants and helper functions shared by the slice header writer.
// ----------------------------------------------------------------------------
package hsw_pkg;

    localparam int FMB_W    = 16;
    localparam int STYPE_W  = 4;
    localparam int FNUM_W   = 16;
    localparam int IDR_ID_W = 16;
    localparam int REFP_W   = 2;
    localparam int QP_W     = 7;
    localparam int BYTE_W   = 8;
    localparam int TAILC_W  = 3;

    // configuration register widths and indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_NUM_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POC_MODE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POC_LSB_BITS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PICTURE_SET_ID = 2'd3;

    localparam int FBITS_W = 5;
    localparam int POCM_W  = 2;
    localparam logic [FBITS_W-1:0] FIELD_BITS_MAX = 5'd16;

    // exp-golomb code word (value + 1) and segment lengths
    localparam int CODE_W  = 17;
    localparam int CIDX_W  = 5;
    localparam int CLEN_W  = 5;
    localparam int SEGN_W  = 6;

    // slice classes
    localparam logic [2:0] CLS_P  = 3'd0;
    localparam logic [2:0] CLS_B  = 3'd1;
    localparam logic [2:0] CLS_I  = 3'd2;
    localparam logic [2:0] CLS_SP = 3'd3;
    localparam logic [2:0] CLS_SI = 3'd4;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_FMB   = 13'b0000000000010,
        ST_STYPE = 13'b0000000000100,
        ST_PPS   = 13'b0000000001000,
        ST_FNUM  = 13'b0000000010000,
        ST_IDR   = 13'b0000000100000,
        ST_POC   = 13'b0000001000000,
        ST_OVR   = 13'b0000010000000,
        ST_FNM1  = 13'b0000100000000,
        ST_REORD = 13'b0001000000000,
        ST_MARK  = 13'b0010000000000,
        ST_QP    = 13'b0100000000000,
        ST_TAIL  = 13'b1000000000000
    } seg_state_t;

    function automatic seg_state_t next_seg(input seg_state_t s);
        seg_state_t r;
        case (s)
            ST_FMB:   r = ST_STYPE;
            ST_STYPE: r = ST_PPS;
            ST_PPS:   r = ST_FNUM;
            ST_FNUM:  r = ST_IDR;
            ST_IDR:   r = ST_POC;
            ST_POC:   r = ST_OVR;
            ST_OVR:   r = ST_FNM1;
            ST_FNM1:  r = ST_REORD;
            ST_REORD: r = ST_MARK;
            ST_MARK:  r = ST_QP;
            ST_QP:    r = ST_TAIL;
            default:  r = ST_IDLE;
        endcase
        return r;
    endfunction

    // slice type modulo 5
    function automatic logic [2:0] slice_class(input logic [STYPE_W-1:0] t);
        logic [2:0] c;
        case (t)
            4'd0, 4'd5, 4'd10, 4'd15: c = CLS_P;
            4'd1, 4'd6, 4'd11:        c = CLS_B;
            4'd2, 4'd7, 4'd12:        c = CLS_I;
            4'd3, 4'd8, 4'd13:        c = CLS_SP;
            default:                  c = CLS_SI;
        endcase
        return c;
    endfunction

    // bit length of a nonzero code word
    function automatic logic [CLEN_W-1:0] code_len(input logic [CODE_W-1:0] c);
        logic [CLEN_W-1:0] l;
        l = '0;
        for (int i = 0; i < CODE_W; i++) begin
            if (c[i])
            begin
                l = CLEN_W'(i + 1);
            end
        end
        return l;
    endfunction

    // a ue code word is its value written in 2*len-1 bits
    function automatic logic [SEGN_W-1:0] ue_bits(input logic [CODE_W-1:0] c);
        logic [CLEN_W-1:0] l;
        l = code_len(c);
        return {l, 1'b0} - SEGN_W'(1);
    endfunction

endpackage

@@ rtl/hsw_req_if.sv @@
// ----------------------------------------------------------------------------
// hsw_req_if
// Slice header request channel: valid/ready plus the request fields.
// ----------------------------------------------------------------------------
interface hsw_req_if;
    logic                            valid;
    logic                            ready;
    logic [hsw_pkg::FMB_W-1:0]       first_macroblock;
    logic [hsw_pkg::STYPE_W-1:0]     slice_type;
    logic [hsw_pkg::FNUM_W-1:0]      frame_number;
    logic                            is_idr;
    logic [hsw_pkg::IDR_ID_W-1:0]    idr_picture_id;
    logic [hsw_pkg::REFP_W-1:0]      ref_priority;
    logic                            ref_count_override;
    logic signed [hsw_pkg::QP_W-1:0] qp_difference;

    modport source (
        output valid, first_macroblock, slice_type, frame_number, is_idr,
               idr_picture_id, ref_priority, ref_count_override, qp_difference,
        input  ready
    );
    modport sink (
        input  valid, first_macroblock, slice_type, frame_number, is_idr,
               idr_picture_id, ref_priority, ref_count_override, qp_difference,
        output ready
    );
endinterface

@@ rtl/hsw_res_if.sv @@
// ----------------------------------------------------------------------------
// hsw_res_if
// Header byte channel: valid/ready plus one byte and tail marking.
// ----------------------------------------------------------------------------
interface hsw_res_if;
    logic                         valid;
    logic                         ready;
    logic [hsw_pkg::BYTE_W-1:0]   out_byte;
    logic [hsw_pkg::TAILC_W-1:0]  tail_bit_count;
    logic                         is_tail;

    modport source (
        output valid, out_byte, tail_bit_count, is_tail,
        input  ready
    );
    modport sink (
        input  valid, out_byte, tail_bit_count, is_tail,
        output ready
    );
endinterface

@@ rtl/h264_slice_header_writer.sv @@
// ----------------------------------------------------------------------------
// h264_slice_header_writer
// Serialises one slice header per request, msb first, into bytes and a tail.
// ----------------------------------------------------------------------------
//   channel | dir | carries
//   req     | in  | slice header request fields
//   res     | out | header bytes, then one tail with the leftover bits
//   cfg     | in  | register writes (enable, index, data)
//
// one header bit leaves the bit shifter per cycle while the shifter is not held;
// each field is first loaded into the shifter before its bits are shifted out,
// and the tail follows the last field.
// a new request is taken only once the tail has entered the output register.
// the shifter holds while a completed byte waits on a full output register.
// reset clears control state and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module h264_slice_header_writer #(
    parameter int MAX_HEADER_BYTES = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    hsw_req_if.sink                            req,
    hsw_res_if.source                          res,
    input  logic                               cfg_we,
    input  logic [hsw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hsw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int HDR_BITS = MAX_HEADER_BYTES * 8;
    localparam int TOT_W    = $clog2(HDR_BITS + 1);

    // configuration
    logic [hsw_pkg::FBITS_W-1:0] fnb_reg;
    logic [hsw_pkg::POCM_W-1:0]  pocm_reg;
    logic [hsw_pkg::FBITS_W-1:0] plb_reg;
    logic [7:0]                  pps_reg;

    // latched request
    logic [hsw_pkg::FMB_W-1:0]       fmb_reg;
    logic [hsw_pkg::STYPE_W-1:0]     stype_reg;
    logic [hsw_pkg::FNUM_W-1:0]      fnum_reg;
    logic                            idr_reg;
    logic [hsw_pkg::IDR_ID_W-1:0]    idr_id_reg;
    logic [hsw_pkg::REFP_W-1:0]      refp_reg;
    logic                            ovr_reg;
    logic signed [hsw_pkg::QP_W-1:0] qp_reg;

    // field shifter
    hsw_pkg::seg_state_t          state_reg, state_next;
    logic                         loaded_reg, loaded_next;
    logic [hsw_pkg::SEGN_W-1:0]   cnt_reg, cnt_next;
    logic [hsw_pkg::CODE_W-1:0]   val_reg, val_next;
    logic [TOT_W-1:0]             tot_reg, tot_next;
    logic [2:0]                   bitcnt_reg, bitcnt_next;
    logic [7:0]                   byte_reg, byte_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   out_byte_reg, out_byte_next;
    logic [2:0]                   out_tcnt_reg, out_tcnt_next;
    logic                         out_tail_reg, out_tail_next;

    logic                         accept;
    logic [2:0]                   cls;
    logic [hsw_pkg::FBITS_W-1:0]  fb;
    logic [hsw_pkg::FBITS_W-1:0]  pb;
    logic [hsw_pkg::SEGN_W-1:0]   ld_n;
    logic [hsw_pkg::CODE_W-1:0]   ld_val;
    logic [hsw_pkg::CODE_W-1:0]   qp_code;
    logic [7:0]                   qp_mag;
    logic [hsw_pkg::SEGN_W-1:0]   cnt_m1;
    logic                         cur_bit;
    logic                         drop;
    logic                         out_free;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == hsw_pkg::ST_IDLE);

    assign res.valid          = out_valid_reg;
    assign res.out_byte       = out_byte_reg;
    assign res.tail_bit_count = out_tcnt_reg;
    assign res.is_tail        = out_tail_reg;

    assign cls = hsw_pkg::slice_class(stype_reg);
    assign fb  = (fnb_reg > hsw_pkg::FIELD_BITS_MAX) ? hsw_pkg::FIELD_BITS_MAX : fnb_reg;
    assign pb  = (plb_reg > hsw_pkg::FIELD_BITS_MAX) ? hsw_pkg::FIELD_BITS_MAX : plb_reg;

    // se mapping: positive q -> 2q, else 2|q|+1 (as code word, value + 1)
    assign qp_mag  = 8'(-{qp_reg[hsw_pkg::QP_W-1], qp_reg});
    assign qp_code = (!qp_reg[hsw_pkg::QP_W-1] && (qp_reg != '0))
                   ? hsw_pkg::CODE_W'({qp_reg, 1'b0})
                   : hsw_pkg::CODE_W'({qp_mag, 1'b1});

    // length and value of the field about to be shifted out
    always_comb
    begin
        ld_n   = '0;
        ld_val = '0;
        case (state_reg)
            hsw_pkg::ST_FMB:
            begin
                ld_val = hsw_pkg::CODE_W'(fmb_reg) + hsw_pkg::CODE_W'(1);
                ld_n   = hsw_pkg::ue_bits(ld_val);
            end
            hsw_pkg::ST_STYPE:
            begin
                ld_val = hsw_pkg::CODE_W'(stype_reg) + hsw_pkg::CODE_W'(1);
                ld_n   = hsw_pkg::ue_bits(ld_val);
            end
            hsw_pkg::ST_PPS:
            begin
                ld_val = hsw_pkg::CODE_W'(pps_reg) + hsw_pkg::CODE_W'(1);
                ld_n   = hsw_pkg::ue_bits(ld_val);
            end
            hsw_pkg::ST_FNUM:
            begin
                ld_val = hsw_pkg::CODE_W'(fnum_reg);
                ld_n   = hsw_pkg::SEGN_W'(fb);
            end
            hsw_pkg::ST_IDR:
            begin
                ld_val = hsw_pkg::CODE_W'(idr_id_reg) + hsw_pkg::CODE_W'(1);
                ld_n   = idr_reg ? hsw_pkg::ue_bits(ld_val) : '0;
            end
            hsw_pkg::ST_POC:
            begin
                ld_val = {fnum_reg, 1'b0};
                ld_n   = (pocm_reg == '0) ? hsw_pkg::SEGN_W'(pb) : '0;
            end
            hsw_pkg::ST_OVR:
            begin
                ld_val = hsw_pkg::CODE_W'(ovr_reg);
                ld_n   = (cls == hsw_pkg::CLS_P || cls == hsw_pkg::CLS_B
                          || cls == hsw_pkg::CLS_SP) ? hsw_pkg::SEGN_W'(1) : '0;
            end
            hsw_pkg::ST_FNM1:
            begin
                // frame_number - 1 wraps to 65535, whose code word is 65536
                ld_val = (fnum_reg == '0) ? {1'b1, {hsw_pkg::FNUM_W{1'b0}}}
                                          : hsw_pkg::CODE_W'(fnum_reg);
                ld_n   = (ovr_reg && cls == hsw_pkg::CLS_P) ? hsw_pkg::ue_bits(ld_val) : '0;
            end
            hsw_pkg::ST_REORD:
            begin
                ld_n = (cls != hsw_pkg::CLS_I && cls != hsw_pkg::CLS_SI)
                     ? hsw_pkg::SEGN_W'(1) : '0;
            end
            hsw_pkg::ST_MARK:
            begin
                if (refp_reg != '0)
                begin
                    ld_n = idr_reg ? hsw_pkg::SEGN_W'(2) : hsw_pkg::SEGN_W'(1);
                end
            end
            hsw_pkg::ST_QP:
            begin
                ld_val = qp_code;
                ld_n   = hsw_pkg::ue_bits(ld_val);
            end
            default:
            begin
                ld_n   = '0;
                ld_val = '0;
            end
        endcase
    end

    assign cnt_m1   = cnt_reg - hsw_pkg::SEGN_W'(1);
    assign cur_bit  = (cnt_m1 < hsw_pkg::SEGN_W'(hsw_pkg::CODE_W))
                    ? val_reg[cnt_m1[hsw_pkg::CIDX_W-1:0]] : 1'b0;
    assign drop     = (tot_reg == TOT_W'(HDR_BITS));
    assign out_free = !out_valid_reg || res.ready;

    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        cnt_next       = cnt_reg;
        val_next       = val_reg;
        tot_next       = tot_reg;
        bitcnt_next    = bitcnt_reg;
        byte_next      = byte_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_byte_next  = out_byte_reg;
        out_tcnt_next  = out_tcnt_reg;
        out_tail_next  = out_tail_reg;

        case (state_reg)
            hsw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next  = hsw_pkg::ST_FMB;
                    loaded_next = 1'b0;
                    tot_next    = '0;
                    bitcnt_next = '0;
                    byte_next   = '0;
                end
            end
            hsw_pkg::ST_TAIL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = byte_reg;
                    out_tcnt_next  = bitcnt_reg;
                    out_tail_next  = 1'b1;
                    state_next     = hsw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                if (!loaded_reg)
                begin
                    cnt_next = ld_n;
                    val_next = ld_val;
                    if (ld_n == '0)
                    begin
                        state_next = hsw_pkg::next_seg(state_reg);
                    end
                    else
                    begin
                        loaded_next = 1'b1;
                    end
                end
                else if (drop || bitcnt_reg != 3'd7 || out_free)
                begin
                    // bits past the buffer limit are dropped
                    if (!drop)
                    begin
                        tot_next = tot_reg + TOT_W'(1);
                        byte_next[3'd7 - bitcnt_reg] = cur_bit;
                        bitcnt_next = bitcnt_reg + 3'd1;
                        if (bitcnt_reg == 3'd7)
                        begin
                            out_valid_next = 1'b1;
                            out_byte_next  = byte_next;
                            out_tcnt_next  = '0;
                            out_tail_next  = 1'b0;
                            byte_next      = '0;
                        end
                    end
                    cnt_next = cnt_m1;
                    if (cnt_reg == hsw_pkg::SEGN_W'(1))
                    begin
                        loaded_next = 1'b0;
                        state_next  = hsw_pkg::next_seg(state_reg);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hsw_pkg::ST_IDLE;
            loaded_reg    <= 1'b0;
            cnt_reg       <= '0;
            tot_reg       <= '0;
            bitcnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            fnb_reg       <= 5'd4;
            pocm_reg      <= '0;
            plb_reg       <= 5'd4;
            pps_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            cnt_reg       <= cnt_next;
            tot_reg       <= tot_next;
            bitcnt_reg    <= bitcnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    hsw_pkg::CFG_FRAME_NUM_BITS: fnb_reg  <= cfg_data[hsw_pkg::FBITS_W-1:0];
                    hsw_pkg::CFG_POC_MODE:       pocm_reg <= cfg_data[hsw_pkg::POCM_W-1:0];
                    hsw_pkg::CFG_POC_LSB_BITS:   plb_reg  <= cfg_data[hsw_pkg::FBITS_W-1:0];
                    hsw_pkg::CFG_PICTURE_SET_ID: pps_reg  <= cfg_data;
                    default:                     pps_reg  <= pps_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        byte_reg     <= byte_next;
        out_byte_reg <= out_byte_next;
        out_tcnt_reg <= out_tcnt_next;
        out_tail_reg <= out_tail_next;
        if (accept)
        begin
            fmb_reg    <= req.first_macroblock;
            stype_reg  <= req.slice_type;
            fnum_reg   <= req.frame_number;
            idr_reg    <= req.is_idr;
            idr_id_reg <= req.idr_picture_id;
            refp_reg   <= req.ref_priority;
            ovr_reg    <= req.ref_count_override;
            qp_reg     <= req.qp_difference;
        end
    end

endmodule
